### hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. They compile away under SYNTHESIS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

### hw/rtl/rlim_pkg.sv
`timescale 1ns / 1ps

package rlim_pkg;

  localparam int BUCKETS_DEF = 64;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX    = 8'd1;

  localparam logic [15:0] WINDOW_RESET = 16'd60;
  localparam logic [15:0] MAX_RESET    = 16'd100;
  localparam logic [15:0] HITS_SAT     = 16'hFFFF;

  typedef struct packed {
    logic [31:0] source;
    logic [15:0] hits;
    logic [31:0] start;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_t;

endpackage

### hw/rtl/per_source_rate_limiter.sv
// A request is taken only in idle; the scan then reads the used buckets in order and stops at
// the first hit; used is the fill count, BUCKETS at most. The scan reads one bucket per cycle
// from the single read port, and a new request is taken only after the last one is written.
// A waiting result holds the next write.
// Reset clears the control state, the fill count and the registers to 60 and 100.
// Table contents are not cleared; buckets past the fill count are never read.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module per_source_rate_limiter #(
  parameter int BUCKETS = rlim_pkg::BUCKETS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [63:0]                    in_tdata,   // client_ip[31:0], now_seconds[63:32]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata,  // limited[0], zero fill[7:1]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rlim_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_data
);

  localparam int IDX_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int CNT_W = $clog2(BUCKETS + 1);
  localparam logic [CNT_W-1:0] FULL = CNT_W'(BUCKETS);

  rlim_pkg::state_t state_r, state_nxt;

  logic [15:0]      window_r, max_r;
  logic [31:0]      ip_r, now_r;
  logic [CNT_W-1:0] issue_r, issue_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_idx_r;
  logic             hit_r, hit_nxt;
  logic [IDX_W-1:0] hit_idx_r;
  logic [15:0]      hit_hits_r;
  logic [31:0]      hit_start_r;
  logic [31:0]      min_start_r;
  logic [IDX_W-1:0] min_idx_r;
  logic             out_valid_r, out_valid_nxt;
  logic             out_limited_r, out_limited_nxt;

  logic             in_fire, issue_fire, eval, match, take_min, wr_fire;
  logic             we;
  logic [IDX_W-1:0] waddr;
  rlim_pkg::entry_t wdata, rd;
  logic [31:0]      elapsed;
  logic [15:0]      hits_inc;

  rlim_ram #(
    .WIDTH ($bits(rlim_pkg::entry_t)),
    .DEPTH (BUCKETS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (issue_r[IDX_W-1:0]),
    .rdata (rd)
  );

  assign in_tready  = rst_n && (state_r == rlim_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_limited_r};

  // A read issued in one cycle returns its bucket in the next, where it is compared.
  assign issue_fire = (state_r == rlim_pkg::ST_SCAN) && !hit_r && (issue_r < used_r);
  assign eval       = pend_r && !hit_r;
  assign match      = eval && (rd.source == ip_r);
  assign take_min   = eval && ((pend_idx_r == '0) || (rd.start < min_start_r));
  assign wr_fire    = (state_r == rlim_pkg::ST_WRITE) && (!out_valid_r || out_tready);

  assign elapsed  = now_r - hit_start_r;
  assign hits_inc = (hit_hits_r == rlim_pkg::HITS_SAT) ? hit_hits_r : hit_hits_r + 16'd1;

  always_comb begin
    state_nxt       = state_r;
    issue_nxt       = issue_r;
    pend_nxt        = 1'b0;
    hit_nxt         = hit_r || match;
    used_nxt        = used_r;
    out_valid_nxt   = out_valid_r;
    out_limited_nxt = out_limited_r;
    we              = 1'b0;
    waddr           = hit_idx_r;
    wdata           = '{source: ip_r, hits: 16'd1, start: now_r};

    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      rlim_pkg::ST_IDLE: begin
        if (in_fire) begin
          issue_nxt = '0;
          hit_nxt   = 1'b0;
          state_nxt = rlim_pkg::ST_SCAN;
        end
      end
      rlim_pkg::ST_SCAN: begin
        pend_nxt = issue_fire;
        if (issue_fire) begin
          issue_nxt = issue_r + CNT_W'(1);
        end
        if (hit_r || (issue_r == used_r && !pend_r)) begin
          state_nxt = rlim_pkg::ST_WRITE;
        end
      end
      rlim_pkg::ST_WRITE: begin
        if (wr_fire) begin
          we              = 1'b1;
          out_valid_nxt   = 1'b1;
          out_limited_nxt = 1'b0;
          state_nxt       = rlim_pkg::ST_IDLE;
          if (hit_r) begin
            if (elapsed < {16'd0, window_r}) begin
              wdata           = '{source: ip_r, hits: hits_inc, start: hit_start_r};
              out_limited_nxt = (hits_inc > max_r);
            end
          end else if (used_r < FULL) begin
            waddr    = used_r[IDX_W-1:0];
            used_nxt = used_r + CNT_W'(1);
          end else begin
            waddr = min_idx_r;
          end
        end
      end
      default: state_nxt = rlim_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlim_pkg::ST_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
      issue_r     <= '0;
      window_r    <= rlim_pkg::WINDOW_RESET;
      max_r       <= rlim_pkg::MAX_RESET;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
      issue_r     <= issue_nxt;
      if (cfg_valid && cfg_index == rlim_pkg::CFG_IDX_WINDOW) begin
        window_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == rlim_pkg::CFG_IDX_MAX) begin
        max_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_limited_r <= out_limited_nxt;
    pend_idx_r    <= issue_r[IDX_W-1:0];
    if (in_fire) begin
      ip_r  <= in_tdata[31:0];
      now_r <= in_tdata[63:32];
    end
    if (match) begin
      hit_idx_r   <= pend_idx_r;
      hit_hits_r  <= rd.hits;
      hit_start_r <= rd.start;
    end
    if (take_min) begin
      min_idx_r   <= pend_idx_r;
      min_start_r <= rd.start;
    end
  end

  `ASSERT_NEVER(a_used_bound, clk, rst_n, used_r > FULL, "fill count beyond table depth")
  `ASSERT_SYNC(a_busy_after_accept, clk, rst_n, in_fire |=> !in_tready, "accepted while busy")
  `ASSERT_SYNC(a_fill_by_one, clk, rst_n,
               (used_r != $past(used_r)) |-> (used_r == $past(used_r) + CNT_W'(1)),
               "fill count jumped")
  `ASSERT_NEVER(a_read_in_range, clk, rst_n, issue_fire && (issue_r >= FULL), "read past table")

endmodule

### hw/rtl/rlim_ram.sv
`timescale 1ns / 1ps

module rlim_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_BUCKETS = rlim_pkg::BUCKETS_DEF;
  localparam int POOL_SIZE   = 96;
  localparam int BURST_BEATS = 40;
  localparam logic [31:0] HOT_SOURCE = 32'h0A00_0001;

  typedef struct packed {
    bit [31:0] now;
    bit [31:0] ip;
  } req_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;           // client_ip[31:0], now_seconds[63:32]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;               // limited[0], zero fill[7:1]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [rlim_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  per_source_rate_limiter #(.BUCKETS(NUM_BUCKETS)) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Traffic and bookkeeping.
  req_t        req_q[$];
  bit          limited_q[$];
  int unsigned items_queued = 0;
  int unsigned items_accepted = 0;
  int unsigned errors = 0;
  bit          no_idle = 1'b1;
  int unsigned send_gap = 0;
  int unsigned out_stall = 0;
  bit [31:0]   src_pool[POOL_SIZE];

  // Shadow copy of the bucket table and the two limit registers.
  bit [31:0]   src_tab[NUM_BUCKETS];
  bit [15:0]   hits_tab[NUM_BUCKETS];
  bit [31:0]   start_tab[NUM_BUCKETS];
  int unsigned filled = 0;
  bit [15:0]   win_len = rlim_pkg::WINDOW_RESET;
  bit [15:0]   max_hits = rlim_pkg::MAX_RESET;

  int unsigned n_limited = 0;
  int unsigned n_fills = 0;
  int unsigned n_evict = 0;
  int unsigned n_restart = 0;
  int unsigned settings_seen = 0;

  function automatic bit rate_decision(bit [31:0] ip, bit [31:0] now);
    int unsigned slot;
    int unsigned oldest;
    bit          found;
    bit [31:0]   elapsed;
    bit          lim;
    found = 1'b0;
    slot = 0;
    lim = 1'b0;
    // The lowest matching index wins, as the hardware scans upward.
    for (int i = 0; i < filled; i++) begin
      if (!found && src_tab[i] == ip) begin
        found = 1'b1;
        slot = i;
      end
    end
    if (found) begin
      elapsed = now - start_tab[slot];
      if (elapsed >= {16'd0, win_len}) begin
        start_tab[slot] = now;
        hits_tab[slot] = 16'd1;
        n_restart++;
      end else begin
        if (hits_tab[slot] != rlim_pkg::HITS_SAT) hits_tab[slot] = hits_tab[slot] + 16'd1;
        lim = (hits_tab[slot] > max_hits);
      end
    end else begin
      if (filled < NUM_BUCKETS) begin
        slot = filled;
        filled++;
      end else begin
        oldest = 0;
        for (int i = 1; i < NUM_BUCKETS; i++) begin
          if (start_tab[i] < start_tab[oldest]) oldest = i;
        end
        slot = oldest;
        n_evict++;
      end
      src_tab[slot] = ip;
      hits_tab[slot] = 16'd1;
      start_tab[slot] = now;
      n_fills++;
    end
    if (lim) n_limited++;
    return lim;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 20);
    return $urandom_range(40, 120);
  endfunction

  task automatic note_mismatch(string what, logic exp_v, logic got_v);
    errors++;
    if (errors <= 10)
      $display("ERROR at %0t: %s: expected limited=%b, got limited=%b", $time, what, exp_v,
               got_v);
  endtask

  always @(posedge clk) begin : drive
    req_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (req_q.size() != 0) begin
        nxt = req_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {nxt.now, nxt.ip};
        send_gap <= (!no_idle && $urandom_range(0, 99) < 40) ? idle_len() : 0;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Checks result beats and predicts every accepted request in one process, so the
  // order of pushes and pops never depends on scheduling.
  always @(posedge clk) begin : observe
    logic got_lim;
    bit   exp_lim;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_lim = out_tdata[0];
        if (limited_q.size() == 0) begin
          note_mismatch("result beat with no request pending", 1'b0, got_lim);
        end else begin
          exp_lim = limited_q.pop_front();
          if (got_lim !== exp_lim) note_mismatch("limited flag", exp_lim, got_lim);
        end
      end
      if (in_tvalid && in_tready) begin
        limited_q.push_back(rate_decision(in_tdata[31:0], in_tdata[63:32]));
        items_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rlim_pkg::CFG_IDX_WINDOW: win_len = cfg_data;
          rlim_pkg::CFG_IDX_MAX:    max_hits = cfg_data;
          default: ;
        endcase
      end
      if (out_stall != 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!no_idle && $urandom_range(0, 99) < 20) out_stall = idle_len();
      end
    end
  end

  task automatic add_req(bit [31:0] ip, bit [31:0] now);
    req_t r;
    r.ip = ip;
    r.now = now;
    req_q.push_back(r);
    items_queued++;
  endtask

  task automatic write_reg(logic [rlim_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(logic [15:0] win, logic [15:0] cap);
    write_reg(rlim_pkg::CFG_IDX_WINDOW, win);
    write_reg(rlim_pkg::CFG_IDX_MAX, cap);
    settings_seen++;
  endtask

  // Hold off until every request has its result, then give the scan time to settle.
  task automatic drain();
    while (items_accepted != items_queued || limited_q.size() != 0) @(posedge clk);
    repeat (NUM_BUCKETS + 8) @(posedge clk);
  endtask

  // Traffic from a pool of sources with a slowly moving clock, plus some noise.
  task automatic random_traffic(int unsigned count, bit [31:0] t0, int unsigned win);
    bit [31:0]   t;
    bit [31:0]   ip;
    int unsigned r;
    t = t0;
    for (int k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        add_req($urandom, $urandom);
      end else begin
        if ($urandom_range(0, 99) < 60) ip = src_pool[$urandom_range(0, 7)];
        else ip = src_pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 99);
        if (r >= 90) t = t + $urandom_range(1, 2 * win + 2);
        else if (r >= 50) t = t + $urandom_range(1, 3);
        add_req(ip, t);
      end
    end
  endtask

  initial begin : stimulus
    bit [15:0] win_set[5];
    bit [15:0] cap_set[5];
    bit [31:0] t_set[5];
    win_set = '{16'd5, 16'd1, 16'd65535, 16'd0, 16'd20};
    cap_set = '{16'd3, 16'd1, 16'd2, 16'd0, 16'd8};
    t_set = '{32'd100, 32'hFFFF_FF80, 32'd5000, 32'h8000_0000, 32'hFFFF_FFF0};
    src_pool[0] = 32'h0000_0000;
    src_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) src_pool[i] = $urandom;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One source hammered back to back inside a single long window; the last
    // beats run past the limit and must be flagged.
    set_limits(16'd65535, 16'd30);
    repeat (BURST_BEATS) add_req(HOT_SOURCE, 32'd1000);
    drain();
    no_idle = 1'b0;

    // Counting up to the limit, window expiry and clock wrap.
    set_limits(16'd3, 16'd2);
    add_req(32'h0000_0000, 32'd0);
    add_req(32'h0000_0000, 32'd1);
    add_req(32'h0000_0000, 32'd2);
    add_req(32'h0000_0000, 32'd3);
    add_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_req(32'hFFFF_FFFF, 32'd1);
    add_req(32'hFFFF_FFFF, 32'd2);
    add_req(HOT_SOURCE, 32'd1002);
    add_req(32'h8000_0000, 32'h8000_0000);
    add_req(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_req(32'h5555_5555, 32'hAAAA_AAAA);
    add_req(32'hAAAA_AAAA, 32'h5555_5555);
    drain();

    // A zero window restarts on every hit; a zero limit blocks every hit in window.
    set_limits(16'd0, 16'd0);
    add_req(32'h0000_0000, 32'd5);
    add_req(32'h0000_0000, 32'd5);
    drain();
    set_limits(16'd65535, 16'd0);
    add_req(32'h0000_0000, 32'd6);
    add_req(32'h1234_5678, 32'd6);
    drain();
    set_limits(16'd1, 16'd1);
    add_req(32'h0000_0000, 32'd6);
    add_req(32'h0000_0000, 32'd7);
    drain();

    // Random phases; the pool is larger than the table, so the full-table
    // replacement and its ties on equal start times get plenty of use.
    for (int p = 0; p < 5; p++) begin
      set_limits(win_set[p], cap_set[p]);
      random_traffic(100, t_set[p], win_set[p]);
      drain();
    end

    $display("Checked %0d requests over %0d limit settings: %0d limited, %0d window restarts.",
             items_accepted, settings_seen, n_limited, n_restart);
    $display("Placed %0d new sources, %0d of them over the oldest bucket of a full table.",
             n_fills, n_evict);
    if (errors == 0) begin
      $display("per_source_rate_limiter test passed");
    end else begin
      $display("per_source_rate_limiter test failed");
    end
    $finish;
  end

  initial begin : watchdog
    #50_000_000;
    $display("Timeout with %0d of %0d requests accepted.", items_accepted, items_queued);
    $display("per_source_rate_limiter test failed");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/rlim_pkg.sv
hw/rtl/rlim_ram.sv
hw/rtl/per_source_rate_limiter.sv
dv/tb_top.sv
